>>> sv/icon_channel_rle_decoder_top_macros.svh
// assertion macros for the icon channel rle decoder
// used by the top level only, relies on clk_i and rst_ni in scope
`ifndef ICON_CHANNEL_RLE_DECODER_TOP_MACROS_SVH
`define ICON_CHANNEL_RLE_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ICRLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icrle check failed");

// next-cycle implication, disabled in reset
`define ICRLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icrle check failed");

`endif

>>> sv/icrle_pkg.sv
// shared types and constants of the icon channel rle decoder
// no dependencies
`timescale 1ns / 1ps

package icrle_pkg;

  // configuration defaults and fixed widths
  localparam int MAX_PIXELS_DEF  = 16384;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int PIXEL_COUNT_RST = 256;
  localparam int CountW          = 15;
  localparam int SkipW           = 4;
  localparam int StartW          = 14;
  localparam int AddrW           = 3;
  localparam int DataW           = 32;
  localparam logic [SkipW-1:0] HEADER_SKIP_RST = '0;

  // register index taken from paddr[2]
  localparam logic REG_PIXEL_COUNT = 1'b0;
  localparam logic REG_HEADER_SKIP = 1'b1;

  // control byte decode
  localparam logic [7:0] CTRL_RUN_MIN = 8'h80;
  localparam logic [7:0] RUN_BIAS     = 8'd125;

  // plane codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_LIT,
    PH_RUN
  } phase_e;

  typedef enum logic [1:0] {
    OP_CTRL,
    OP_LIT,
    OP_RUN
  } op_kind_e;

  // one classified word passed from front to back
  typedef struct packed {
    op_kind_e   kind;
    logic       lit_more;
    logic [7:0] run_len;
    logic [7:0] data;
  } icrle_op_t;

  // restart request raised by a register write
  typedef struct packed {
    logic             restart;
    logic [SkipW-1:0] skip;
  } icrle_restart_t;

endpackage

>>> sv/icrle_front.sv
// front part: header skip and control byte classification
// depends on icrle_pkg
`timescale 1ns / 1ps

module icrle_front import icrle_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  icrle_restart_t restart_i,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           full_i,
  output logic           push_o,
  output icrle_op_t      op_o
);

  phase_e           phase_q, phase_d;
  logic [SkipW-1:0] skip_left_q, skip_left_d;
  logic [7:0]       lit_left_q, lit_left_d;
  logic [7:0]       rep_len_q, rep_len_d;
  logic             fire;
  logic             decode;
  logic [7:0]       lit_dec;

  assign fire    = in_valid_i && !full_i;
  assign decode  = fire && (skip_left_q == '0);
  assign lit_dec = lit_left_q - 8'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (restart_i.restart) begin
      phase_d = PH_CTRL;
    end else if (decode) begin
      case (phase_q)
        PH_CTRL: phase_d = (in_byte_i < CTRL_RUN_MIN) ? PH_LIT : PH_RUN;
        PH_LIT:  phase_d = (lit_dec == 8'd0) ? PH_CTRL : PH_LIT;
        PH_RUN:  phase_d = PH_CTRL;
        default: phase_d = PH_CTRL;
      endcase
    end
  end

  // word to the queue and counters
  always_comb begin
    push_o        = decode;
    op_o.kind     = OP_CTRL;
    op_o.lit_more = 1'b0;
    op_o.run_len  = rep_len_q;
    op_o.data     = in_byte_i;
    skip_left_d   = skip_left_q;
    lit_left_d    = lit_left_q;
    rep_len_d     = rep_len_q;
    if (restart_i.restart) begin
      skip_left_d = restart_i.skip;
      lit_left_d  = '0;
      rep_len_d   = '0;
    end else if (fire && (skip_left_q != '0)) begin
      skip_left_d = skip_left_q - SkipW'(1);
    end else if (decode) begin
      case (phase_q)
        PH_CTRL: begin
          op_o.kind = OP_CTRL;
          if (in_byte_i < CTRL_RUN_MIN) begin
            lit_left_d = in_byte_i + 8'd1;
          end else begin
            rep_len_d = in_byte_i - RUN_BIAS;
          end
        end
        PH_LIT: begin
          op_o.kind     = OP_LIT;
          op_o.lit_more = (lit_dec != 8'd0);
          lit_left_d    = lit_dec;
        end
        PH_RUN: begin
          op_o.kind = OP_RUN;
        end
        default: op_o.kind = OP_CTRL;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CTRL;
      skip_left_q <= HEADER_SKIP_RST;
      lit_left_q  <= '0;
      rep_len_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      skip_left_q <= skip_left_d;
      lit_left_q  <= lit_left_d;
      rep_len_q   <= rep_len_d;
    end
  end

endmodule

>>> sv/icrle_queue.sv
// short queue of classified words between front and back
// depends on icrle_pkg
`timescale 1ns / 1ps

module icrle_queue import icrle_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      flush_i,
  input  logic      push_i,
  input  icrle_op_t push_data_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output icrle_op_t head_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  icrle_op_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (flush_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      cnt_d    = '0;
    end else begin
      if (do_push) begin
        wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_d = cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push && !flush_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/icrle_back.sv
// back part: plane and pixel tracking, clipping, result register
// depends on icrle_pkg
`timescale 1ns / 1ps

module icrle_back import icrle_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  localparam int PosW = $clog2(MAX_PIXELS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  icrle_restart_t    restart_i,
  input  logic [PosW-1:0]   eff_count_i,
  input  logic              op_valid_i,
  input  icrle_op_t         op_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        channel_o,
  output logic [StartW-1:0] start_pixel_o,
  output logic [7:0]        run_length_o,
  output logic [7:0]        pixel_value_o,
  output logic              overrun_o,
  output logic              image_done_o,
  output logic              excess_byte_o
);

  logic [1:0]      plane_q, plane_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            finished_q, finished_d;
  logic            out_valid_q, out_valid_d;

  logic [PosW-1:0] avail;
  logic            clip;
  logic [7:0]      run_len_c;
  logic            lit_in;
  logic            lit_last;
  logic [PosW-1:0] pos_after;
  logic            end_plane;
  logic            need_out;
  logic            out_free;
  logic            load;

  logic [1:0]        r_ch;
  logic [StartW-1:0] r_start;
  logic [7:0]        r_len;
  logic [7:0]        r_val;
  logic              r_ov;
  logic              r_done;
  logic              r_excess;

  // run clipping and plane end detection
  always_comb begin
    avail     = eff_count_i - pos_q;
    clip      = 32'(op_i.run_len) > 32'(avail);
    run_len_c = clip ? 8'(avail) : op_i.run_len;
    lit_in    = pos_q < eff_count_i;
    lit_last  = (PosW'(pos_q + PosW'(1)) == eff_count_i);
    pos_after = pos_q;
    end_plane = 1'b0;
    case (op_i.kind)
      OP_LIT: begin
        pos_after = lit_in ? PosW'(pos_q + PosW'(1)) : pos_q;
        end_plane = !op_i.lit_more && (pos_after >= eff_count_i);
      end
      OP_RUN: begin
        pos_after = PosW'(pos_q + PosW'(run_len_c));
        end_plane = (pos_after >= eff_count_i);
      end
      default: begin
        pos_after = pos_q;
        end_plane = 1'b0;
      end
    endcase
  end

  // result fields
  always_comb begin
    r_ch     = plane_q;
    r_start  = StartW'(pos_q);
    r_len    = 8'd1;
    r_val    = op_i.data;
    r_ov     = 1'b0;
    r_done   = 1'b0;
    r_excess = 1'b0;
    need_out = 1'b0;
    if (finished_q) begin
      need_out = 1'b1;
      r_ch     = '0;
      r_start  = '0;
      r_len    = '0;
      r_val    = '0;
      r_excess = 1'b1;
    end else begin
      case (op_i.kind)
        OP_LIT: begin
          need_out = lit_in;
          r_len    = 8'd1;
          r_ov     = lit_last && op_i.lit_more;
          r_done   = lit_last && (plane_q == CH_BLUE);
        end
        OP_RUN: begin
          need_out = 1'b1;
          r_len    = run_len_c;
          r_ov     = clip;
          r_done   = (pos_after >= eff_count_i) && (plane_q == CH_BLUE);
        end
        default: need_out = 1'b0;
      endcase
    end
  end

  // pop when the result, if any, has room
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = op_valid_i && (!need_out || out_free);
  assign load     = pop_o && need_out;

  // plane and position update
  always_comb begin
    plane_d    = plane_q;
    pos_d      = pos_q;
    finished_d = finished_q;
    if (restart_i.restart) begin
      plane_d    = CH_RED;
      pos_d      = '0;
      finished_d = 1'b0;
    end else if (pop_o && !finished_q) begin
      if (end_plane) begin
        pos_d = '0;
        if (plane_q == CH_BLUE) begin
          finished_d = 1'b1;
        end else begin
          plane_d = plane_q + 2'd1;
        end
      end else begin
        pos_d = pos_after;
      end
    end
  end

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q     <= CH_RED;
      pos_q       <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      plane_q     <= plane_d;
      pos_q       <= pos_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      channel_o     <= r_ch;
      start_pixel_o <= r_start;
      run_length_o  <= r_len;
      pixel_value_o <= r_val;
      overrun_o     <= r_ov;
      image_done_o  <= r_done;
      excess_byte_o <= r_excess;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/icon_channel_rle_decoder_top.sv
// top level of the icon channel rle decoder: register port, front, queue, back
// depends on icrle_pkg, icrle_front, icrle_queue, icrle_back and the macro header
`timescale 1ns / 1ps
//
// Takes one compressed byte per word on the input channel (in_valid_i,
// in_stall_o, in_byte_i) and returns run descriptors on the output channel
// (out_valid_o, out_stall_i and the result fields). Header bytes, control
// bytes and literal bytes past the plane end give no word; every other byte
// gives exactly one.
// Throughput is one byte per cycle while in_stall_o is low. An accepted byte
// past the header is written to the queue, and its result is loaded from the
// queue head into the result register once that register has room, raising
// out_valid_o. The queue holds two words by default (QUEUE_DEPTH), so the input
// keeps flowing while a result waits; once the receiver stalls long enough to
// fill it, in_stall_o rises and stays high until the back end drains a word.
// Register writes (pixel_count at 0x0, header_skip at 0x4) restart decoding
// from the red plane and reload the header skip; issue them only while idle.
// Reset clears all control state and sets pixel_count to 256, header_skip
// to 0. After the blue plane each further byte returns an excess word.
//
`include "icon_channel_rle_decoder_top_macros.svh"

module icon_channel_rle_decoder_top import icrle_pkg::*; #(
  parameter int MAX_PIXELS  = MAX_PIXELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        channel_o,
  output logic [StartW-1:0] start_pixel_o,
  output logic [7:0]        run_length_o,
  output logic [7:0]        pixel_value_o,
  output logic              overrun_o,
  output logic              image_done_o,
  output logic              excess_byte_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int PosW   = $clog2(MAX_PIXELS + 1);
  localparam int RstEff = (PIXEL_COUNT_RST > MAX_PIXELS) ? MAX_PIXELS : PIXEL_COUNT_RST;

  logic [CountW-1:0] pixel_count_q;
  logic [SkipW-1:0]  header_skip_q;
  logic [PosW-1:0]   eff_count_q, eff_wr;
  logic [CountW-1:0] wr_count;
  logic              cfg_wr;
  icrle_restart_t    restart;

  logic      push;
  icrle_op_t push_op;
  logic      q_full;
  logic      q_valid;
  icrle_op_t q_head;
  logic      pop;

  // register port
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign wr_count = pwdata[CountW-1:0];

  always_comb begin
    if (wr_count == '0) begin
      eff_wr = PosW'(1);
    end else if (32'(wr_count) > 32'(MAX_PIXELS)) begin
      eff_wr = PosW'(MAX_PIXELS);
    end else begin
      eff_wr = PosW'(wr_count);
    end
  end

  always_comb begin
    restart.restart = cfg_wr;
    restart.skip    = (paddr[2] == REG_HEADER_SKIP) ? pwdata[SkipW-1:0] : header_skip_q;
  end

  always_comb begin
    if (paddr[2] == REG_HEADER_SKIP) begin
      prdata = DataW'(header_skip_q);
    end else begin
      prdata = DataW'(pixel_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_count_q <= CountW'(PIXEL_COUNT_RST);
      eff_count_q   <= PosW'(RstEff);
      header_skip_q <= HEADER_SKIP_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PIXEL_COUNT) begin
        pixel_count_q <= wr_count;
        eff_count_q   <= eff_wr;
      end else begin
        header_skip_q <= pwdata[SkipW-1:0];
      end
    end
  end

  // front, queue and back
  assign in_stall_o = q_full;

  icrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .full_i     (q_full),
    .push_o     (push),
    .op_o       (push_op)
  );

  icrle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (restart.restart),
    .push_i      (push),
    .push_data_i (push_op),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  icrle_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .eff_count_i   (eff_count_q),
    .op_valid_i    (q_valid),
    .op_i          (q_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_o     (channel_o),
    .start_pixel_o (start_pixel_o),
    .run_length_o  (run_length_o),
    .pixel_value_o (pixel_value_o),
    .overrun_o     (overrun_o),
    .image_done_o  (image_done_o),
    .excess_byte_o (excess_byte_o)
  );

  // checks
  `ICRLE_ASSERT_IMP(a_excess_zero, out_valid_o && excess_byte_o,
    channel_o == '0 && start_pixel_o == '0 && run_length_o == '0 &&
    pixel_value_o == '0 && !overrun_o && !image_done_o)
  `ICRLE_ASSERT_IMP(a_run_nonzero, out_valid_o && !excess_byte_o,
    run_length_o != '0 && channel_o != 2'd3)
  `ICRLE_ASSERT_IMP(a_done_blue, out_valid_o && image_done_o, channel_o == CH_BLUE)
  `ICRLE_ASSERT_NXT(a_restart_clear, cfg_wr, !q_valid)

endmodule

>>> tb/icon_channel_rle_decoder_top_tb.sv
// testbench for the icon channel rle decoder: directed and random byte streams
// drives both handshake channels and the apb-style register port of the top level
// depends on icrle_pkg and icon_channel_rle_decoder_top
`timescale 1ns / 1ps

module icon_channel_rle_decoder_top_tb import icrle_pkg::*;;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 11;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // one run descriptor as it leaves the block
  typedef struct packed {
    logic [1:0]        channel;
    logic [StartW-1:0] start_pixel;
    logic [7:0]        run_length;
    logic [7:0]        pixel_value;
    logic              overrun;
    logic              image_done;
    logic              excess_byte;
  } run_word_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [7:0]        in_byte_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        channel_o;
  logic [StartW-1:0] start_pixel_o;
  logic [7:0]        run_length_o;
  logic [7:0]        pixel_value_o;
  logic              overrun_o;
  logic              image_done_o;
  logic              excess_byte_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [DataW-1:0]  pwdata      = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  icon_channel_rle_decoder_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_o     (channel_o),
    .start_pixel_o (start_pixel_o),
    .run_length_o  (run_length_o),
    .pixel_value_o (pixel_value_o),
    .overrun_o     (overrun_o),
    .image_done_o  (image_done_o),
    .excess_byte_o (excess_byte_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // decoder state mirrored on the testbench side
  logic [CountW-1:0] cfg_pixel_count;
  logic [SkipW-1:0]  cfg_header_skip;
  logic [SkipW-1:0]  exp_skip_left;
  logic [1:0]        exp_plane;
  logic [CountW-1:0] exp_pos;
  phase_e            exp_phase;
  logic [7:0]        exp_lit_left;
  logic [7:0]        exp_rep_len;
  bit                exp_finished;

  run_word_t   pending_runs[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_errors      = 0;
  int unsigned n_bytes       = 0;
  int unsigned n_items       = 0;
  int unsigned n_words       = 0;
  int unsigned n_images      = 0;
  int unsigned idle_cycles   = 0;

  // control byte encodings
  function automatic logic [7:0] lit_ctrl(input int unsigned len);
    return 8'(len - 1);
  endfunction

  function automatic logic [7:0] run_ctrl(input int unsigned len);
    return 8'(len + RUN_BIAS);
  endfunction

  // pixel count as the decoder uses it, clamped to 1..max
  function automatic logic [CountW-1:0] plane_size();
    if (cfg_pixel_count == 0) return CountW'(1);
    if (cfg_pixel_count > MAX_PIXELS_DEF) return CountW'(MAX_PIXELS_DEF);
    return cfg_pixel_count;
  endfunction

  function automatic void restart_decode();
    exp_skip_left = cfg_header_skip;
    exp_plane     = CH_RED;
    exp_pos       = '0;
    exp_phase     = PH_CTRL;
    exp_lit_left  = '0;
    exp_rep_len   = '0;
    exp_finished  = 1'b0;
  endfunction

  function automatic void next_plane();
    exp_pos = '0;
    if (exp_plane == CH_BLUE) exp_finished = 1'b1;
    else exp_plane = exp_plane + 2'd1;
  endfunction

  // advance the mirrored decoder by one byte, queue the run word it gives;
  // returns 0 for a byte that the block only drops
  function automatic bit predict_runs(input logic [7:0] b);
    logic [CountW-1:0] size;
    logic [CountW-1:0] avail;
    logic [CountW-1:0] len;
    bit                last;
    run_word_t         w;
    size = plane_size();
    w = '0;
    predict_runs = 1'b1;
    if (exp_finished) begin
      w.excess_byte = 1'b1;
      pending_runs.push_back(w);
    end else if (exp_skip_left != 0) begin
      exp_skip_left = exp_skip_left - 1'b1;
      predict_runs = 1'b0;
    end else begin
      case (exp_phase)
        PH_LIT: begin
          exp_lit_left = exp_lit_left - 8'd1;
          if (exp_pos < size) begin
            last          = (exp_pos + 1 == size);
            w.channel     = exp_plane;
            w.start_pixel = exp_pos[StartW-1:0];
            w.run_length  = 8'd1;
            w.pixel_value = b;
            w.overrun     = last && (exp_lit_left != 0);
            w.image_done  = last && (exp_plane == CH_BLUE);
            pending_runs.push_back(w);
            exp_pos = exp_pos + 1'b1;
          end else begin
            predict_runs = 1'b0;
          end
          if (exp_lit_left == 0) begin
            exp_phase = PH_CTRL;
            if (exp_pos >= size) next_plane();
          end
        end
        PH_RUN: begin
          avail = size - exp_pos;
          len   = CountW'(exp_rep_len);
          w.overrun = (len > avail);
          if (w.overrun) len = avail;
          w.channel     = exp_plane;
          w.start_pixel = exp_pos[StartW-1:0];
          w.run_length  = len[7:0];
          w.pixel_value = b;
          w.image_done  = (exp_pos + len >= size) && (exp_plane == CH_BLUE);
          pending_runs.push_back(w);
          exp_pos   = exp_pos + len;
          exp_phase = PH_CTRL;
          if (exp_pos >= size) next_plane();
        end
        default: begin
          if (b < CTRL_RUN_MIN) begin
            exp_lit_left = b + 8'd1;
            exp_phase    = PH_LIT;
          end else begin
            exp_rep_len = b - RUN_BIAS;
            exp_phase   = PH_RUN;
          end
        end
      endcase
    end
  endfunction

  function automatic void note_error(input string what, input run_word_t want,
                                     input run_word_t got);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("%0t %s: expected ch=%0d start=%0d len=%0d val=%02h ov=%0b done=%0b exc=%0b",
               $realtime, what,
               want.channel, want.start_pixel, want.run_length, want.pixel_value,
               want.overrun, want.image_done, want.excess_byte);
      $display("    got ch=%0d start=%0d len=%0d val=%02h ov=%0b done=%0b exc=%0b",
               got.channel, got.start_pixel, got.run_length, got.pixel_value,
               got.overrun, got.image_done, got.excess_byte);
    end
  endfunction

  // result side: compare each accepted word, then pick the next stall
  always @(posedge clk_i) begin
    run_word_t got;
    run_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {channel_o, start_pixel_o, run_length_o, pixel_value_o,
             overrun_o, image_done_o, excess_byte_o};
      n_words++;
      if (image_done_o) n_images++;
      if (pending_runs.size() == 0) begin
        note_error("unexpected word", '0, got);
      end else begin
        want = pending_runs.pop_front();
        if (got !== want) note_error("mismatch", want, got);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout with %0d words outstanding", pending_runs.size());
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // one byte on the input channel, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= value;
    do @(posedge clk_i); while (in_stall_o);
    n_bytes++;
    if (predict_runs(value)) n_items++;
  endtask

  // stop sending and let every outstanding word arrive
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // apb write: setup cycle, access cycle, then bus released
  task automatic write_reg(input logic reg_idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_PIXEL_COUNT) cfg_pixel_count = value[CountW-1:0];
    else cfg_header_skip = value[SkipW-1:0];
    restart_decode();
    @(posedge clk_i);
  endtask

  // well-formed packets covering one plane, the last one may overrun
  task automatic send_plane(input int unsigned count, input int unsigned long_pct);
    int unsigned left;
    int unsigned len;
    left = count;
    while (left > 0) begin
      if ($urandom_range(1)) begin
        len = ($urandom_range(99) < long_pct) ? 130 : $urandom_range(3, 20);
        if (len > left && left >= 3 && $urandom_range(1)) len = left;
        send_byte(run_ctrl(len));
        send_byte(8'($urandom_range(255)));
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
        if (len > left && $urandom_range(1)) len = left;
        send_byte(lit_ctrl(len));
        repeat (len) send_byte(8'($urandom_range(255)));
      end
      left = (len >= left) ? 0 : left - len;
    end
  endtask

  task automatic send_header();
    repeat (cfg_header_skip) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_image(input int unsigned long_pct);
    send_header();
    repeat (3) send_plane(plane_size(), long_pct);
  endtask

  // new register setting while idle; junk in the upper data bits
  task automatic pick_setting();
    int unsigned       sel;
    logic [CountW-1:0] count;
    logic [SkipW-1:0]  skip;
    sel = $urandom_range(99);
    if (sel < 6) count = '0;
    else if (sel < 14) count = CountW'(1);
    else if (sel < 18) count = CountW'($urandom_range(100, 300));
    else count = CountW'($urandom_range(2, 40));
    sel = $urandom_range(99);
    if (sel < 15) skip = '0;
    else if (sel < 30) skip = '1;
    else skip = SkipW'($urandom_range(15));
    wait_idle();
    sel = $urandom_range(2);
    if (sel != 1)
      write_reg(REG_PIXEL_COUNT, ($urandom() & ~DataW'(16'h7FFF)) | DataW'(count));
    if (sel != 0)
      write_reg(REG_HEADER_SKIP, ($urandom() & ~DataW'(4'hF)) | DataW'(skip));
  endtask

  // reset values: 256 pixels, no header
  task automatic test_defaults();
    send_byte(run_ctrl(130));
    send_byte(8'h00);
    send_byte(run_ctrl(3));
    send_byte(8'hFF);
    send_byte(lit_ctrl(1));
    send_byte(8'hA5);
    send_byte(lit_ctrl(2));
    send_byte(8'h5A);
    send_byte(8'hC3);
    wait_idle();
  endtask

  // longest header, exact literal fit, clipped run, clipped literal group, excess
  task automatic test_header_and_clipping();
    write_reg(REG_HEADER_SKIP, DataW'(15));
    write_reg(REG_PIXEL_COUNT, DataW'(3));
    repeat (15) send_byte(8'hFF);
    send_byte(lit_ctrl(3));
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(run_ctrl(130));
    send_byte(8'h77);
    send_byte(lit_ctrl(6));
    repeat (6) send_byte(8'($urandom_range(255)));
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_idle();
  endtask

  // pixel count zero acts as one pixel per plane
  task automatic test_zero_count();
    write_reg(REG_HEADER_SKIP, DataW'(0));
    write_reg(REG_PIXEL_COUNT, DataW'(0));
    send_byte(run_ctrl(3));
    send_byte(8'h11);
    send_byte(lit_ctrl(1));
    send_byte(8'h22);
    send_byte(lit_ctrl(2));
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h55);
    wait_idle();
  endtask

  // widest pixel count register value, clamped to the largest plane
  task automatic test_largest_image();
    wait_idle();
    write_reg(REG_HEADER_SKIP, DataW'(4));
    write_reg(REG_PIXEL_COUNT, DataW'(16'h7FFF));
    send_header();
    // longest runs only, the last run of each plane is clipped
    repeat (3) begin
      repeat (127) begin
        send_byte(run_ctrl(130));
        send_byte(8'($urandom_range(255)));
      end
    end
    send_byte(8'($urandom_range(255)));
    wait_idle();
  endtask

  // mostly whole images, some cut short, some plain noise
  task automatic test_random_streams(input int unsigned budget);
    int unsigned stop_at;
    int unsigned sel;
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      pick_setting();
      sel = $urandom_range(99);
      if (sel < 70) begin
        send_image(30);
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)));
      end else if (sel < 85) begin
        send_header();
        send_plane(plane_size(), 30);
      end else begin
        repeat ($urandom_range(5, 40)) send_byte(8'($urandom_range(255)));
      end
    end
    wait_idle();
  endtask

  initial begin
    cfg_pixel_count = CountW'(PIXEL_COUNT_RST);
    cfg_header_skip = HEADER_SKIP_RST;
    restart_decode();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 46;
    test_defaults();
    test_header_and_clipping();
    test_zero_count();
    test_random_streams(300);
    test_largest_image();

    send_idle_pct = 46;
    recv_idle_pct = 19;
    test_random_streams(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(300);

    wait_idle();
    $display("sent %0d bytes (%0d decoded), checked %0d run words, %0d images completed",
             n_bytes, n_items, n_words, n_images);
    $display("pixel counts 0 to 32767, header skips 0 to 15, three idling modes, %0d errors",
             n_errors);
    if (n_errors == 0 && pending_runs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/icrle_pkg.sv
sv/icrle_front.sv
sv/icrle_queue.sv
sv/icrle_back.sv
sv/icon_channel_rle_decoder_top.sv
tb/icon_channel_rle_decoder_top_tb.sv
